[sv/htfl_pkg.sv]
// Package for the handle table free list: sizes, action and status codes,
// controller states. No dependencies; imported by the top level and the testbench.
package htfl_pkg;

  // Table geometry
  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = $clog2(CAPACITY);      // index of a slot row, slot - 1
  localparam int LINK_W   = $clog2(CAPACITY + 1);  // slot number 0..CAPACITY
  localparam int VALUE_W  = 32;
  localparam int ENTRY_W  = VALUE_W + 1;           // {valid, tag}

  // Action codes of an input transaction
  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2
  } action_t;

  // Status codes of a result transaction
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

[sv/handle_table_free_list.sv]
// Top level of the handle table with a linked free list.
// Depends on htfl_pkg and two htfl_ram instances (links, slot entries).
//
// Use:
//   Input channel (in_valid / in_stall) carries action, handle and object_value;
//   output channel (out_valid / out_stall) carries handle_out, object_out, found
//   and status. Every input transaction yields exactly one result transaction.
//   Create takes the head of the free list and returns start_index + slot;
//   delete returns a valid slot to the tail; get reads the stored tag.
//   The user writes start_index (cfg_we/cfg_data) only when idle; not enforced.
// Timing:
//   The accept edge issues one registered read of the link memory and of the
//   slot memory; the edge that ends S_EXEC, once the output register is free,
//   writes back and loads the output register. Only then does the block return
//   to S_IDLE and take a new input, so it handles one transaction at a time.
// Reset:
//   rst starts a clearing pass over all CAPACITY slot rows that builds the free
//   list in order and marks every slot empty; in_stall is high throughout.
// Stalls:
//   A waiting result sits in the output register; one further transaction is
//   accepted and read, then held until the output register frees.
module handle_table_free_list
  import htfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [30:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] handle,
  input  logic [31:0] object_value,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] handle_out,
  output logic [31:0] object_out,
  output logic        found,
  output logic [1:0]  status
);

  localparam logic [SLOT_W-1:0] LAST_ROW = SLOT_W'(CAPACITY - 1);

  state_t              state, state_next;
  logic [SLOT_W-1:0]   clr_cnt;
  logic [LINK_W-1:0]   head, head_next;
  logic [LINK_W-1:0]   tail, tail_next;
  logic [30:0]         start_index;

  // latched transaction
  logic [1:0]          op_action;
  logic [31:0]         op_handle;
  logic [31:0]         op_value;
  logic [SLOT_W-1:0]   op_slot;
  logic                op_in_range;

  // memory ports
  logic                link_we, slot_we;
  logic [SLOT_W-1:0]   link_waddr, slot_waddr;
  logic [LINK_W-1:0]   link_wdata, link_rdata;
  logic [ENTRY_W-1:0]  slot_wdata, slot_rdata;
  logic [SLOT_W-1:0]   slot_raddr;

  // result
  logic                out_load;
  logic [31:0]         res_handle, res_object;
  logic                res_found;
  status_t             res_status;

  logic                in_acc;
  logic [31:0]         offset;
  logic                in_range;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Translate the external handle to a slot row
  assign offset     = handle - {1'b0, start_index};
  assign in_range   = (handle >= {1'b0, start_index}) && (offset != 32'd0) &&
                      (offset <= 32'(CAPACITY));
  assign slot_raddr = SLOT_W'(offset - 32'd1);

  htfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (LINK_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (in_acc),
    .raddr (SLOT_W'(head - LINK_W'(1))),
    .rdata (link_rdata)
  );

  htfl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (in_acc),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      head        <= LINK_W'(1);
      tail        <= LINK_W'(CAPACITY);
      start_index <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
      if (cfg_we) begin
        start_index <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_action   <= action;
      op_handle   <= handle;
      op_value    <= object_value;
      op_slot     <= slot_raddr;
      op_in_range <= in_range;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      handle_out <= res_handle;
      object_out <= res_object;
      found      <= res_found;
      status     <= res_status;
    end
  end

  // Next state, write-back and result
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    link_we    = 1'b0;
    link_waddr = clr_cnt;
    link_wdata = '0;
    slot_we    = 1'b0;
    slot_waddr = clr_cnt;
    slot_wdata = '0;
    out_load   = 1'b0;
    res_handle = op_handle;
    res_object = '0;
    res_found  = 1'b0;
    res_status = STAT_OK;

    case (state)
      S_CLEAR: begin
        // Chain every slot to its successor, end the list at the last, mark it empty
        link_we    = 1'b1;
        link_wdata = (clr_cnt == LAST_ROW) ? '0 : LINK_W'(clr_cnt) + LINK_W'(2);
        slot_we    = 1'b1;
        if (clr_cnt == LAST_ROW) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        // Hold the read data until the output register frees
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          case (op_action)
            ACT_CREATE: begin
              if (head == '0) begin
                res_handle = '0;
                res_status = STAT_FULL;
              end else begin
                // Pop the head slot, terminate its link, store the tag
                link_we    = 1'b1;
                link_waddr = SLOT_W'(head - LINK_W'(1));
                link_wdata = '0;
                slot_we    = 1'b1;
                slot_waddr = SLOT_W'(head - LINK_W'(1));
                slot_wdata = {1'b1, op_value};
                head_next  = link_rdata;
                if (link_rdata == '0) begin
                  tail_next = '0;
                end
                res_handle = 32'(start_index) + 32'(head);
              end
            end
            ACT_DELETE, ACT_GET: begin
              if (!op_in_range) begin
                res_status = STAT_RANGE;
              end else if (!slot_rdata[ENTRY_W-1]) begin
                res_status = STAT_EMPTY;
              end else if (op_action == ACT_DELETE) begin
                // Free the slot and append it at the tail
                slot_we    = 1'b1;
                slot_waddr = op_slot;
                slot_wdata = '0;
                if (tail == '0) begin
                  head_next = LINK_W'(op_slot) + LINK_W'(1);
                end else begin
                  link_we    = 1'b1;
                  link_waddr = SLOT_W'(tail - LINK_W'(1));
                  link_wdata = LINK_W'(op_slot) + LINK_W'(1);
                end
                tail_next = LINK_W'(op_slot) + LINK_W'(1);
              end else begin
                res_object = slot_rdata[VALUE_W-1:0];
                res_found  = 1'b1;
              end
            end
            default: begin
              // unused action: echo only
            end
          endcase
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // An empty free list has neither head nor tail
  a_head_tail_empty: assert property (@(posedge clk) disable iff (rst)
    (head == '0) == (tail == '0))
    else $error("free list head and tail disagree on emptiness");

  // A full table answers with a zero handle and nothing found
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_FULL) |-> (handle_out == '0) && !found)
    else $error("table full result carries a handle or a tag");

  // A found tag only comes with an ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (status == STAT_OK))
    else $error("found set on a failed transaction");

  // No transaction is taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(state == S_CLEAR) && (state == S_CLEAR) |-> !out_load && !in_acc)
    else $error("transaction handled while clearing");

endmodule

[sv/htfl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the free-list links and the slot entries; no package dependency.
module htfl_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/sv/tb_handle_table_free_list.sv]
// Self-checking testbench for handle_table_free_list: a scoreboard class tracks
// the free list and slot contents and checks every result transaction in order.
// Depends on htfl_pkg and the handle_table_free_list top level.
module tb_handle_table_free_list
  import htfl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] handle_out;
    logic [31:0] object_out;
    logic        found;
    status_t     status;
  } reply_t;

  // Tracks table state and the replies still owed by the block
  class htfl_scoreboard;
    bit [LINK_W-1:0] link_of [0:CAPACITY];
    bit [LINK_W-1:0] tail;
    bit [31:0]       tag_of  [1:CAPACITY];
    bit              live    [1:CAPACITY];
    bit [30:0]       base;
    int unsigned     live_q[$];
    reply_t          owed_replies[$];
    int              mismatches;

    function new();
      for (int i = 0; i < CAPACITY; i++) link_of[i] = LINK_W'(i + 1);
      link_of[CAPACITY] = '0;
      tail = LINK_W'(CAPACITY);
      for (int i = 1; i <= CAPACITY; i++) begin
        tag_of[i] = '0;
        live[i]   = 1'b0;
      end
      base = '0;
      mismatches = 0;
    endfunction

    // Handle of a slot in use, or any in-range handle when none is in use
    function logic [31:0] some_live_handle();
      if (live_q.size() == 0) return {1'b0, base} + $urandom_range(1, CAPACITY);
      return {1'b0, base} + live_q[$urandom_range(live_q.size() - 1)];
    endfunction

    // Apply one accepted request to the table and queue the reply it owes
    function void note_request(logic [1:0] act, logic [31:0] h, logic [31:0] obj);
      reply_t      r;
      int unsigned slot, succ;
      logic [31:0] offs;
      r.handle_out = h;
      r.object_out = '0;
      r.found      = 1'b0;
      r.status     = STAT_OK;
      if (act == ACT_CREATE) begin
        slot = link_of[0];
        if (slot == 0 || slot > CAPACITY) begin
          r.handle_out = '0;
          r.status     = STAT_FULL;
        end else begin
          succ = link_of[slot];
          link_of[0] = LINK_W'(succ);
          if (succ == 0) tail = '0;
          link_of[slot] = '0;
          tag_of[slot]  = obj;
          live[slot]    = 1'b1;
          live_q        = {live_q, slot};
          r.handle_out  = {1'b0, base} + slot;
        end
      end else if (act == ACT_DELETE || act == ACT_GET) begin
        // map handle to slot; no wrap below the base, slot bound 1..CAPACITY
        slot = 0;
        if (h >= {1'b0, base}) begin
          offs = h - {1'b0, base};
          if (offs >= 1 && offs <= CAPACITY) slot = offs;
        end
        if (slot == 0) begin
          r.status = STAT_RANGE;
        end else if (!live[slot]) begin
          r.status = STAT_EMPTY;
        end else if (act == ACT_DELETE) begin
          live[slot]   = 1'b0;
          tag_of[slot] = '0;
          if (tail <= CAPACITY) link_of[tail] = LINK_W'(slot);
          tail = LINK_W'(slot);
          foreach (live_q[i]) begin
            if (live_q[i] == slot) begin
              live_q.delete(i);
              break;
            end
          end
        end else begin
          r.object_out = tag_of[slot];
          r.found      = 1'b1;
        end
      end
      owed_replies = {owed_replies, r};
    endfunction

    // Compare one result transaction with the oldest owed reply
    function void check_reply(logic [31:0] ho, logic [31:0] oo, logic fnd, logic [1:0] st);
      reply_t e;
      if (owed_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: handle_out=%h object_out=%h found=%b status=%0d",
                   ho, oo, fnd, st);
        return;
      end
      e = owed_replies.pop_front();
      if (ho !== e.handle_out || oo !== e.object_out || fnd !== e.found ||
          st !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp handle_out=%h object_out=%h found=%b status=%0d, got %h %h %b %0d",
                   e.handle_out, e.object_out, e.found, e.status, ho, oo, fnd, st);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [30:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [31:0] handle;
  logic [31:0] object_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] handle_out;
  logic [31:0] object_out;
  logic        found;
  logic [1:0]  status;

  int send_idle_pct;
  int recv_idle_pct;
  htfl_scoreboard sb = new();

  handle_table_free_list DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .handle       (handle),
    .object_value (object_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .handle_out   (handle_out),
    .object_out   (object_out),
    .found        (found),
    .status       (status)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Observe both channels at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_reply(handle_out, object_out, found, status);
      if (in_valid && !in_stall) sb.note_request(action, handle, object_value);
    end
  end

  // Offer one transaction, with random gaps before it, and hold until taken
  task automatic send_item(input logic [1:0] a, input logic [31:0] h, input logic [31:0] obj);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= a;
    handle       <= h;
    object_value <= obj;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every owed reply has arrived
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write start_index once the block is idle
  task automatic write_start_index(input logic [30:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.base = v;
    cfg_we <= 1'b0;
  endtask

  // Handles around the range edges, or plain noise
  function automatic logic [31:0] odd_handle();
    logic [31:0] b;
    b = {1'b0, sb.base};
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return b;
      2:       return b - 1;
      3:       return b + CAPACITY + 1;
      4:       return b + CAPACITY;
      default: return b + $urandom_range(1, CAPACITY);
    endcase
  endfunction

  // One random transaction: mostly well formed, the rest noise
  task automatic random_item(input int pc, input int pd, input int pg);
    int          r;
    logic [31:0] obj;
    r   = $urandom_range(99);
    obj = $urandom;
    if (r < pc) send_item(ACT_CREATE, $urandom, obj);
    else if (r < pc + pd) send_item(ACT_DELETE, sb.some_live_handle(), obj);
    else if (r < pc + pd + pg) send_item(ACT_GET, sb.some_live_handle(), obj);
    else send_item(2'($urandom_range(3)), odd_handle(), obj);
  endtask

  // Finish on a hung run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    bit filled;
    int n;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    action        = ACT_CREATE;
    handle        = '0;
    object_value  = '0;
    out_stall     = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 0;
    filled        = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    recv_idle_pct = 50;

    // wait out the clearing pass
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // directed: base 0
    write_start_index(31'd0);
    send_item(ACT_CREATE, 32'h0, 32'h0);
    send_item(ACT_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'd1, 32'h0);
    send_item(ACT_GET, 32'd2, 32'h0);
    send_item(ACT_GET, 32'd0, 32'h0);
    send_item(ACT_GET, CAPACITY + 1, 32'h0);
    send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_GET, CAPACITY, 32'h0);
    send_item(ACT_DELETE, 32'd1, 32'h0);
    send_item(ACT_DELETE, 32'd1, 32'h0);
    send_item(ACT_GET, 32'd1, 32'h0);
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_DELETE, CAPACITY + 1, 32'h0);
    send_item(ACT_CREATE, 32'h0, 32'hA5A5_5A5A);

    // directed: largest base, handles below it and past the slot bound
    write_start_index(31'h7FFF_FFFF);
    send_item(ACT_GET, 32'h0, 32'h0);
    send_item(ACT_GET, 32'h7FFF_FFFE, 32'h0);
    send_item(ACT_GET, 32'h7FFF_FFFF, 32'h0);
    send_item(ACT_CREATE, 32'h0, 32'h0000_1234);
    send_item(ACT_GET, 32'h7FFF_FFFF + 2, 32'h0);
    send_item(ACT_DELETE, 32'h7FFF_FFFF + 2, 32'h0);
    send_item(ACT_GET, 32'h7FFF_FFFF + CAPACITY + 1, 32'h0);
    send_item(ACT_GET, 32'h7FFF_FFFF + CAPACITY, 32'h0);
    send_item(2'd3, 32'h0, 32'h0);

    // random, sender idles a little and receiver a lot
    write_start_index(31'($urandom));
    for (int i = 0; i < 400; i++) random_item(80, 5, 10);

    // random, roles swapped: fill the table, then churn around full
    send_idle_pct = 50;
    recv_idle_pct = 9;
    write_start_index(31'd0);
    for (int i = 0; i < 900; i++) begin
      if (i == 200) settle();
      if (sb.live_q.size() == CAPACITY) filled = 1'b1;
      if (!filled) random_item(98, 1, 1);
      else random_item(40, 35, 15);
    end

    // random, no idling, delete heavy
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_start_index(31'($urandom));
    for (int i = 0; i < 250; i++) random_item(20, 50, 20);

    // drain and report
    in_valid <= 1'b0;
    @(posedge clk);
    n = 0;
    while (sb.owed_replies.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/htfl_pkg.sv
sv/htfl_ram.sv
sv/handle_table_free_list.sv
tb/sv/tb_handle_table_free_list.sv
